### rtl/eat_pkg.sv
// ----------------------------------------------------------------------------
// eat_pkg
// shared types and constants of the encoder angle tracker
// ----------------------------------------------------------------------------
`default_nettype none

package eat_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int TURN_BITS  = 16;
  localparam int POS_BITS   = TURN_BITS + ANGLE_BITS;
  localparam int CNT_BITS   = 16;
  localparam int TIME_BITS  = 32;
  localparam int RAW_BITS   = 8;

  // compare width wide enough for any angle step and the step limit
  localparam int STEP_BITS  = 12;
  localparam int CMP_BITS   = ((ANGLE_BITS > STEP_BITS) ? ANGLE_BITS : STEP_BITS) + 1;

  // status byte bit positions
  localparam int ST_MD_BIT = 5;
  localparam int ST_ML_BIT = 4;
  localparam int ST_MH_BIT = 3;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // stream widths
  localparam int IN_FIELD_BITS  = 3 * RAW_BITS + TIME_BITS;
  localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = ANGLE_BITS + TURN_BITS + POS_BITS + 3 + 2 * CNT_BITS;
  localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_READ_ERR = 2'd1,
    OP_STATUS   = 2'd2,
    OP_INIT     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_MAX_STEP   = 2'd0,
    CFG_MAX_REJECT = 2'd1,
    CFG_MAX_AGE    = 2'd2
  } cfg_index_t;

  localparam logic [STEP_BITS-1:0] MAX_STEP_RST   = STEP_BITS'(256);
  localparam logic [CNT_BITS-1:0]  MAX_REJECT_RST = CNT_BITS'(3);
  localparam logic [TIME_BITS-1:0] MAX_AGE_RST    = TIME_BITS'(5);

  typedef struct packed {
    logic [STEP_BITS-1:0] max_step;
    logic [CNT_BITS-1:0]  max_reject;
    logic [TIME_BITS-1:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0]       last_angle;
    logic signed [TURN_BITS-1:0] turn_count;
    logic [TIME_BITS-1:0]        last_good_time;
    logic [CNT_BITS-1:0]         errors;
    logic [CNT_BITS-1:0]         rejects;
    logic                        magnet_seen;
    logic                        sample_valid;
  } track_state_t;

  // per-item flags from the update logic
  typedef struct packed {
    logic published;
    logic fresh;
  } upd_flags_t;

endpackage

`default_nettype wire

### rtl/eat_update.sv
// ----------------------------------------------------------------------------
// eat_update
// one-event update of the tracker state: step fold, reject budget, status
// ----------------------------------------------------------------------------
`default_nettype none

module eat_update
  import eat_pkg::*;
(
  input  wire op_t                   op,
  input  wire logic [ANGLE_BITS-1:0] ang,
  input  wire logic [RAW_BITS-1:0]   status_byte,
  input  wire logic [TIME_BITS-1:0]  now,
  input  wire cfg_t                  cfg,
  input  wire track_state_t          cur,
  output track_state_t               nxt,
  output upd_flags_t                 flags
);

  localparam logic signed [ANGLE_BITS:0] HALF = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS:0] FULL = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  logic signed [ANGLE_BITS:0] delta_raw;
  logic signed [ANGLE_BITS:0] delta;
  logic signed [ANGLE_BITS:0] mag;
  logic                       wrap_up;
  logic                       wrap_dn;
  logic                       oversized;
  logic                       status_ok;
  logic [CNT_BITS-1:0]        errors_inc;
  logic [TIME_BITS-1:0]       age;
  logic                       vres;

  always_comb begin
    delta_raw = $signed({1'b0, ang}) - $signed({1'b0, cur.last_angle});
    wrap_dn   = delta_raw > HALF;
    wrap_up   = delta_raw < -HALF;
    if (wrap_dn) begin
      delta = delta_raw - FULL;
    end else if (wrap_up) begin
      delta = delta_raw + FULL;
    end else begin
      delta = delta_raw;
    end
    mag       = delta[ANGLE_BITS] ? -delta : delta;
    oversized = CMP_BITS'($unsigned(mag)) > CMP_BITS'(cfg.max_step);
    status_ok = status_byte[ST_MD_BIT] && !status_byte[ST_ML_BIT] && !status_byte[ST_MH_BIT];
    errors_inc = (cur.errors != CNT_MAX) ? cur.errors + CNT_BITS'(1) : cur.errors;
  end

  always_comb begin
    nxt = cur;
    flags.published = 1'b0;
    unique case (op)
      OP_SAMPLE: begin
        if (oversized && (cur.rejects < cfg.max_reject)) begin
          nxt.sample_valid = 1'b0;
          nxt.errors       = errors_inc;
          nxt.rejects      = cur.rejects + CNT_BITS'(1);
        end else begin
          if (wrap_up && (cur.turn_count != TURN_MAX)) begin
            nxt.turn_count = cur.turn_count + TURN_BITS'(1);
          end else if (wrap_dn && (cur.turn_count != TURN_MIN)) begin
            nxt.turn_count = cur.turn_count - TURN_BITS'(1);
          end
          nxt.last_angle     = ang;
          nxt.last_good_time = now;
          nxt.errors         = '0;
          nxt.rejects        = '0;
          nxt.sample_valid   = 1'b1;
          flags.published    = 1'b1;
        end
      end
      OP_READ_ERR: begin
        nxt.sample_valid = 1'b0;
        nxt.errors       = errors_inc;
      end
      OP_STATUS: begin
        if (!status_ok) begin
          nxt.magnet_seen  = 1'b0;
          nxt.sample_valid = 1'b0;
        end
      end
      OP_INIT: begin
        nxt = '0;
        if (status_ok) begin
          nxt.magnet_seen    = 1'b1;
          nxt.last_angle     = ang;
          nxt.last_good_time = now;
          nxt.sample_valid   = 1'b1;
          flags.published    = 1'b1;
        end else begin
          nxt.errors = CNT_BITS'(1);
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    // age from the previous good time, or from zero for an init; a publish with the magnet seen is fresh
    age         = now - ((op == OP_INIT) ? '0 : cur.last_good_time);
    vres        = nxt.sample_valid && nxt.magnet_seen;
    flags.fresh = vres && (flags.published || (age <= cfg.max_age));
  end

endmodule

`default_nettype wire

### rtl/encoder_angle_tracker_unit.sv
// ----------------------------------------------------------------------------
// encoder_angle_tracker_unit
// multi-turn angle tracker for a 12-bit absolute rotary encoder
// ----------------------------------------------------------------------------
// throughput: one event per cycle when m_tready does not hold the result register
// data path: input register -> update logic -> result register
// the state update of one event is ready for the next event in the next cycle
// reset: synchronous; clears tracker state, both pipeline valids, and loads
// max_step 256, max_reject 3, max_age 5
`default_nettype none

module encoder_angle_tracker_unit
  import eat_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  // event input
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // raw_high[7:0], raw_low[15:8], status_byte[23:16], now[55:24]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // op[1:0]
  input  wire logic [1:0]             s_tuser,

  // result output
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // angle[11:0], turns[27:12], position[55:28], valid_res[56], magnet_ok[57],
  // fresh[58], err_count[74:59], reject_count[90:75], zero fill above
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // published[0]
  output logic                        m_tuser,

  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [TIME_BITS-1:0]   cfg_data
);

  // input register
  logic                  in_valid;
  op_t                   in_op;
  logic [ANGLE_BITS-1:0] in_ang;
  logic [RAW_BITS-1:0]   in_status;
  logic [TIME_BITS-1:0]  in_now;

  // tracker state and configuration
  track_state_t state;
  track_state_t state_next;
  upd_flags_t   flags;
  cfg_t         cfg;

  // result register
  logic                        out_valid;
  logic [ANGLE_BITS-1:0]       out_angle;
  logic signed [TURN_BITS-1:0] out_turns;
  logic                        out_published;
  logic                        out_valid_res;
  logic                        out_magnet_ok;
  logic                        out_fresh;
  logic [CNT_BITS-1:0]         out_errors;
  logic [CNT_BITS-1:0]         out_rejects;

  logic advance;
  logic s_accept;

  // the update stage moves when the result register is free or being drained
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // input register; angle is the low bits of the big-endian byte pair
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_accept) begin
      in_op     <= op_t'(s_tuser);
      in_ang    <= ANGLE_BITS'({s_tdata[RAW_BITS-1:0], s_tdata[2*RAW_BITS-1:RAW_BITS]});
      in_status <= s_tdata[3*RAW_BITS-1:2*RAW_BITS];
      in_now    <= s_tdata[3*RAW_BITS+TIME_BITS-1:3*RAW_BITS];
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_step   <= MAX_STEP_RST;
      cfg.max_reject <= MAX_REJECT_RST;
      cfg.max_age    <= MAX_AGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_STEP:   cfg.max_step   <= cfg_data[STEP_BITS-1:0];
        CFG_MAX_REJECT: cfg.max_reject <= cfg_data[CNT_BITS-1:0];
        CFG_MAX_AGE:    cfg.max_age    <= cfg_data;
        default:        cfg            <= cfg;
      endcase
    end
  end

  eat_update u_update (
    .op          (in_op),
    .ang         (in_ang),
    .status_byte (in_status),
    .now         (in_now),
    .cfg         (cfg),
    .cur         (state),
    .nxt         (state_next),
    .flags       (flags)
  );

  // state commits together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_angle     <= state_next.last_angle;
      out_turns     <= state_next.turn_count;
      out_published <= flags.published;
      out_valid_res <= state_next.sample_valid && state_next.magnet_seen;
      out_magnet_ok <= state_next.magnet_seen;
      out_fresh     <= flags.fresh;
      out_errors    <= state_next.errors;
      out_rejects   <= state_next.rejects;
    end
  end

  // position is turns * 2^ANGLE_BITS + angle, i.e. the two side by side
  assign m_tvalid = out_valid;
  assign m_tuser  = out_published;
  assign m_tdata  = OUT_TDATA_W'({out_rejects, out_errors, out_fresh, out_magnet_ok,
                                  out_valid_res, out_turns, out_angle, out_turns,
                                  out_angle});

  // tracker state only moves when an event goes through the update stage
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("tracker state changed without an event");

  // a publish always clears the error and reject counters
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_published |-> (out_errors == '0) && (out_rejects == '0))
    else $error("published result with nonzero error or reject count");

  // fresh needs a valid sample with the magnet present
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fresh |-> out_valid_res && out_magnet_ok)
    else $error("fresh result without a valid sample");

  // a reject leaves the counter within the configured budget
  assert property (@(posedge clk) disable iff (rst)
    advance && (in_op == OP_SAMPLE) && !flags.published |->
      (state_next.rejects <= cfg.max_reject) && (state_next.rejects != '0))
    else $error("reject count outside budget");

endmodule

`default_nettype wire

### bench/tb_encoder_angle_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_encoder_angle_tracker_unit
// self-checking bench for the multi-turn encoder angle tracker
//
// A directed table covers reset values, the extremes of the fields, every
// event kind and the corner cases of the unwrap: half-turn steps, the reject
// budget, turn folding across zero and loss of the magnet. Random phases with
// fresh register settings follow, each with a stretch of words back to back.
// Every result word is compared field by field against a bench-side tracker
// model, or against a fixed expectation on some directed rows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_encoder_angle_tracker_unit;
  import eat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_TURN      = 1 << ANGLE_BITS;
  localparam int HALF_TURN      = FULL_TURN / 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOW_LIMIT     = 40;
  localparam int PHASES         = 6;
  localparam int PHASE_EVENTS   = 250;

  // result word layout, lowest bit first
  localparam int OFS_TURNS = ANGLE_BITS;
  localparam int OFS_POS   = OFS_TURNS + TURN_BITS;
  localparam int OFS_VALID = OFS_POS + POS_BITS;
  localparam int OFS_ERR   = OFS_VALID + 3;
  localparam int OFS_REJ   = OFS_ERR + CNT_BITS;

  localparam logic signed [TURN_BITS-1:0] TURN_TOP = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_BOT = ~TURN_TOP;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic [TURN_BITS-1:0]  turns;
    logic [POS_BITS-1:0]   position;
    logic                  published;
    logic                  valid_res;
    logic                  magnet_ok;
    logic                  fresh;
    logic [CNT_BITS-1:0]   err_count;
    logic [CNT_BITS-1:0]   reject_count;
  } tracker_result_t;

  // one row of the directed table: a register write or an event
  typedef struct packed {
    logic                 is_reg;
    cfg_index_t           idx;
    logic [TIME_BITS-1:0] val;
    op_t                  op;
    logic [7:0]           hi;
    logic [7:0]           lo;
    logic [7:0]           st;
    logic [TIME_BITS-1:0] now;
    logic                 typed;
    tracker_result_t      res;
  } stim_row_t;

  // dut ports
  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [1:0]             s_tuser   = OP_SAMPLE;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = CFG_MAX_STEP;
  logic [TIME_BITS-1:0]   cfg_data  = '0;

  // bench copy of the tracker state and registers
  logic [ANGLE_BITS-1:0]       trk_angle;
  logic signed [TURN_BITS-1:0] trk_turns;
  logic [TIME_BITS-1:0]        trk_good_time;
  logic [CNT_BITS-1:0]         trk_errors;
  logic [CNT_BITS-1:0]         trk_rejects;
  logic                        trk_magnet;
  logic                        trk_valid;
  logic [STEP_BITS-1:0]        reg_max_step   = MAX_STEP_RST;
  logic [CNT_BITS-1:0]         reg_max_reject = MAX_REJECT_RST;
  logic [TIME_BITS-1:0]        reg_max_age    = MAX_AGE_RST;

  tracker_result_t pending_results[$];
  stim_row_t       stim_table[$];

  logic                 idle_on    = 1'b1;
  int                   ready_hold = 0;
  int                   quiet_cycles = 0;
  logic [TIME_BITS-1:0] tick = '0;

  int n_events     = 0;
  int n_directed   = 0;
  int n_reg_writes = 0;
  int n_results    = 0;
  int n_published  = 0;
  int mismatches   = 0;

  encoder_angle_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // tracker model
  // ---------------------------------------------------------------------------

  function automatic void clear_tracker();
    trk_angle     = '0;
    trk_turns     = '0;
    trk_good_time = '0;
    trk_errors    = '0;
    trk_rejects   = '0;
    trk_magnet    = 1'b0;
    trk_valid     = 1'b0;
  endfunction

  // any error drops the valid flag; the count sticks at all ones
  function automatic void bump_error();
    trk_valid = 1'b0;
    if (trk_errors != CNT_MAX) trk_errors = trk_errors + 1'b1;
  endfunction

  function automatic void take_sample(logic [ANGLE_BITS-1:0] ang, logic [TIME_BITS-1:0] now);
    trk_angle     = ang;
    trk_good_time = now;
    trk_errors    = '0;
    trk_rejects   = '0;
    trk_valid     = 1'b1;
  endfunction

  function automatic tracker_result_t track_event(op_t op, logic [7:0] hi, logic [7:0] lo,
                                                  logic [7:0] st, logic [TIME_BITS-1:0] now);
    logic [ANGLE_BITS-1:0] ang;
    logic [TIME_BITS-1:0]  age;
    int                    step;
    int                    fold;
    int                    mag;
    logic                  take;
    logic                  pub;
    logic                  good;
    tracker_result_t       r;
    ang  = ANGLE_BITS'({hi, lo});
    step = int'(ang) - int'(trk_angle);
    fold = 0;
    take = 1'b1;
    pub  = 1'b0;
    good = st[ST_MD_BIT] && !st[ST_ML_BIT] && !st[ST_MH_BIT];
    case (op)
      OP_SAMPLE: begin
        // fold into -half..+half, exact half turns stay as they are
        if (step > HALF_TURN) begin
          step = step - FULL_TURN;
          fold = -1;
        end else if (step < -HALF_TURN) begin
          step = step + FULL_TURN;
          fold = 1;
        end
        mag = (step < 0) ? -step : step;
        if (mag > int'(reg_max_step)) begin
          bump_error();
          if (trk_rejects < reg_max_reject) begin
            trk_rejects = trk_rejects + 1'b1;
            take = 1'b0;
          end
        end
        if (take) begin
          if (fold > 0 && trk_turns != TURN_TOP) trk_turns = trk_turns + 1'b1;
          else if (fold < 0 && trk_turns != TURN_BOT) trk_turns = trk_turns - 1'b1;
          take_sample(ang, now);
          pub = 1'b1;
        end
      end
      OP_READ_ERR: bump_error();
      OP_STATUS: begin
        if (!good) begin
          trk_magnet = 1'b0;
          trk_valid  = 1'b0;
        end
      end
      default: begin
        clear_tracker();
        if (!good) begin
          bump_error();
        end else begin
          trk_magnet = 1'b1;
          take_sample(ang, now);
          pub = 1'b1;
        end
      end
    endcase
    age            = now - trk_good_time;
    r.angle        = trk_angle;
    r.turns        = trk_turns;
    r.position     = POS_BITS'(int'(trk_turns) * FULL_TURN + int'(trk_angle));
    r.published    = pub;
    r.valid_res    = trk_valid && trk_magnet;
    r.magnet_ok    = trk_magnet;
    r.fresh        = r.valid_res && (age <= reg_max_age);
    r.err_count    = trk_errors;
    r.reject_count = trk_rejects;
    return r;
  endfunction

  function automatic tracker_result_t mk_result(int angle, int turns, int position, logic pub,
                                                logic vres, logic mag, logic fresh,
                                                int errs, int rejs);
    tracker_result_t r;
    r.angle        = ANGLE_BITS'(angle);
    r.turns        = TURN_BITS'(turns);
    r.position     = POS_BITS'(position);
    r.published    = pub;
    r.valid_res    = vres;
    r.magnet_ok    = mag;
    r.fresh        = fresh;
    r.err_count    = CNT_BITS'(errs);
    r.reject_count = CNT_BITS'(rejs);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one event word; the expectation is stored at the accepting edge
  task automatic push_event(op_t op, logic [7:0] hi, logic [7:0] lo, logic [7:0] st,
                            logic [TIME_BITS-1:0] now, logic typed, tracker_result_t typed_res);
    int              gap;
    tracker_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, st, lo, hi};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = track_event(op, hi, lo, st, now);
    pending_results.push_back(typed ? typed_res : r);
    n_events++;
  endtask

  // registers change only with the pipeline drained
  task automatic write_reg(cfg_index_t idx, logic [TIME_BITS-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_STEP:   reg_max_step   = STEP_BITS'(val);
      CFG_MAX_REJECT: reg_max_reject = CNT_BITS'(val);
      default:        reg_max_age    = val;
    endcase
    n_reg_writes++;
  endtask

  function automatic void add_event(op_t op, logic [7:0] hi, logic [7:0] lo, logic [7:0] st,
                                    logic [TIME_BITS-1:0] now, logic typed,
                                    tracker_result_t res);
    stim_row_t row;
    row        = '0;
    row.op     = op;
    row.hi     = hi;
    row.lo     = lo;
    row.st     = st;
    row.now    = now;
    row.typed  = typed;
    row.res    = res;
    stim_table.push_back(row);
  endfunction

  function automatic void add_reg(cfg_index_t idx, logic [TIME_BITS-1:0] val);
    stim_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    stim_table.push_back(row);
  endfunction

  // result side back pressure
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      m_tready   <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      m_tready   <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t %s mismatch: expected %h actual %h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    tracker_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t unexpected result word: expected none actual %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("angle", want.angle, m_tdata[0 +: ANGLE_BITS]);
        check_field("turns", want.turns, m_tdata[OFS_TURNS +: TURN_BITS]);
        check_field("position", want.position, m_tdata[OFS_POS +: POS_BITS]);
        check_field("published", want.published, m_tuser);
        check_field("valid_res", want.valid_res, m_tdata[OFS_VALID]);
        check_field("magnet_ok", want.magnet_ok, m_tdata[OFS_VALID + 1]);
        check_field("fresh", want.fresh, m_tdata[OFS_VALID + 2]);
        check_field("err_count", want.err_count, m_tdata[OFS_ERR +: CNT_BITS]);
        check_field("reject_count", want.reject_count, m_tdata[OFS_REJ +: CNT_BITS]);
        check_field("zero fill", '0, m_tdata[OUT_TDATA_W-1:OUT_FIELD_BITS]);
        if (want.published) n_published++;
      end
    end
  end

  // watchdog on cycles where no channel moves a word
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t             row;
    tracker_result_t       none;
    op_t                   op;
    logic [ANGLE_BITS-1:0] ang;
    logic [7:0]            st;
    int                    i;
    int                    p;
    int                    sel;
    int                    lim;
    int                    step;

    none = '0;
    clear_tracker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset register values until the first write row
    // first word after reset: a read error on a clean tracker
    add_event(OP_READ_ERR, 8'h00, 8'h00, 8'h00, 32'd0, 1'b1,
              mk_result(0, 0, 0, 0, 0, 0, 0, 1, 0));
    // sample without magnet publishes but never reports valid
    add_event(OP_SAMPLE, 8'h01, 8'h00, 8'hFF, 32'd10, 1'b0, none);
    add_event(OP_STATUS, 8'h00, 8'h00, 8'h00, 32'd11, 1'b0, none);
    // init with weak and strong set: cleared state plus one error
    add_event(OP_INIT, 8'hFF, 8'hFF, 8'h38, 32'd12, 1'b1,
              mk_result(0, 0, 0, 0, 0, 0, 0, 1, 0));
    // good init at the top angle and the top tick, upper raw bits masked
    add_event(OP_INIT, 8'hFF, 8'hFF, 8'h20, 32'hFFFF_FFFF, 1'b1,
              mk_result(4095, 0, 4095, 1, 1, 1, 1, 0, 0));
    // forward wrap through zero while the tick wraps
    add_event(OP_SAMPLE, 8'h00, 8'h00, 8'h20, 32'd2, 1'b0, none);
    // backward wrap
    add_event(OP_SAMPLE, 8'h0F, 8'hF0, 8'h20, 32'd3, 1'b0, none);
    // oversized step: three rejects, then taken anyway
    for (i = 0; i < 4; i++)
      add_event(OP_SAMPLE, 8'h08, 8'h00, 8'h20, 32'd4 + i, 1'b0, none);
    add_event(OP_SAMPLE, 8'h08, 8'h00, 8'h20, 32'd100, 1'b0, none);
    // good status leaves the state, but the sample is stale by now
    add_event(OP_STATUS, 8'h00, 8'h00, 8'h20, 32'd106, 1'b0, none);
    // weak magnet drops magnet and valid
    add_event(OP_STATUS, 8'h00, 8'h00, 8'h30, 32'd107, 1'b0, none);
    add_event(OP_SAMPLE, 8'h08, 8'h10, 8'h20, 32'd108, 1'b0, none);
    add_reg(CFG_MAX_STEP, 32'd2048);
    add_reg(CFG_MAX_REJECT, 32'd0);
    add_reg(CFG_MAX_AGE, 32'hFFFF_FFFF);
    add_event(OP_INIT, 8'h00, 8'h00, 8'h20, 32'd0, 1'b1,
              mk_result(0, 0, 0, 1, 1, 1, 1, 0, 0));
    // exact half turn up and down, neither folded
    add_event(OP_SAMPLE, 8'h08, 8'h00, 8'h00, 32'd1, 1'b0, none);
    add_event(OP_SAMPLE, 8'h00, 8'h00, 8'h00, 32'd2, 1'b0, none);
    // zero step limit and no reject budget: oversized sample taken, counters cleared
    add_reg(CFG_MAX_STEP, 32'd0);
    add_event(OP_SAMPLE, 8'h00, 8'h01, 8'h00, 32'd3, 1'b0, none);
    add_event(OP_READ_ERR, 8'h00, 8'h00, 8'h00, 32'd4, 1'b0, none);
    // strong magnet
    add_event(OP_STATUS, 8'h00, 8'h00, 8'h08, 32'd5, 1'b0, none);

    foreach (stim_table[k]) begin
      row = stim_table[k];
      if (row.is_reg) begin
        write_reg(row.idx, row.val);
      end else begin
        push_event(row.op, row.hi, row.lo, row.st, row.now, row.typed, row.res);
        n_directed++;
      end
    end

    // random phases, each with its own register setting
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        write_reg(CFG_MAX_STEP, 32'd0);
        write_reg(CFG_MAX_REJECT, 32'd65535);
        write_reg(CFG_MAX_AGE, 32'd0);
      end else if (p == 1) begin
        write_reg(CFG_MAX_STEP, 32'd2048);
        write_reg(CFG_MAX_REJECT, 32'd0);
        write_reg(CFG_MAX_AGE, 32'hFFFF_FFFF);
      end else begin
        sel = $urandom_range(0, 3);
        write_reg(CFG_MAX_STEP, (sel == 0) ? 32'd0 : (sel == 1) ? 32'd2048 :
                                32'($urandom_range(1, 2047)));
        sel = $urandom_range(0, 3);
        write_reg(CFG_MAX_REJECT, (sel == 0) ? 32'd0 : (sel == 1) ? 32'd65535 :
                                  32'($urandom_range(1, 6)));
        sel = $urandom_range(0, 3);
        write_reg(CFG_MAX_AGE, (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
                               32'($urandom_range(1, 12)));
      end
      // start each phase from a good init so samples get tracked
      ang = ANGLE_BITS'($urandom_range(0, FULL_TURN - 1));
      push_event(OP_INIT, {4'($urandom_range(0, 15)), ang[11:8]}, ang[7:0], 8'h20, tick,
                 1'b0, none);
      for (i = 0; i < PHASE_EVENTS; i++) begin
        // a stretch without any idling in every phase
        idle_on = !(i >= 100 && i < 140);
        if ($urandom_range(0, 19) == 0) tick = $urandom();
        else tick = tick + $urandom_range(0, 3);
        sel = $urandom_range(0, 99);
        st  = 8'($urandom_range(0, 255));
        if (sel < 72) begin
          op  = OP_SAMPLE;
          lim = int'(reg_max_step) + 2;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: step = int'($urandom_range(0, 2 * lim)) - lim;
            6, 7, 8:          step = int'($urandom_range(0, FULL_TURN - 1));
            default: begin
              // boundaries of the fold and of the step limit
              case ($urandom_range(0, 3))
                0:       step = HALF_TURN;
                1:       step = -HALF_TURN;
                2:       step = int'(reg_max_step);
                default: step = -(int'(reg_max_step) + 1);
              endcase
            end
          endcase
          ang = ANGLE_BITS'(int'(trk_angle) + step);
        end else begin
          ang = ANGLE_BITS'($urandom_range(0, FULL_TURN - 1));
          if (sel < 80) begin
            op = OP_READ_ERR;
          end else if (sel < 90) begin
            op = OP_STATUS;
            if ($urandom_range(0, 1) != 0) st = (st | 8'h20) & 8'hE7;
          end else begin
            op = OP_INIT;
            if ($urandom_range(0, 3) != 0) st = (st | 8'h20) & 8'hE7;
          end
        end
        push_event(op, {4'($urandom_range(0, 15)), ang[11:8]}, ang[7:0], st, tick,
                   1'b0, none);
      end
      idle_on = 1'b1;
    end

    // drain
    s_tvalid <= 1'b0;
    idle_on = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d events (%0d from the directed table), %0d register writes",
             n_events, n_directed, n_reg_writes);
    $display("checked %0d result words, %0d published samples, %0d mismatches",
             n_results, n_published, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/eat_pkg.sv
rtl/eat_update.sv
rtl/encoder_angle_tracker_unit.sv
bench/tb_encoder_angle_tracker_unit.sv
